[src/rme_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// Depends on nothing; every other file imports it.
package rme_pkg;

	localparam int RME_WIDTH = 32;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 4;

	typedef enum logic [1:0] {
		REG_PUBLIC_EXP  = 2'd0,
		REG_PRIVATE_EXP = 2'd1,
		REG_MODULUS     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQR,
		ST_MUL,
		ST_DONE
	} state_t;

endpackage

[src/rme_cell.sv]
// One step of the shift-and-add modular multiplier: double, then add on the multiplier MSB.
// Depends on rme_pkg (for the house import only).
module rme_cell #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] n,
	input  logic             valid_i,
	input  logic [WIDTH-1:0] acc_i,
	input  logic [WIDTH-1:0] a_i,
	input  logic [WIDTH-1:0] b_i,
	output logic             valid_o,
	output logic [WIDTH-1:0] acc_o,
	output logic [WIDTH-1:0] a_o,
	output logic [WIDTH-1:0] b_o
);
	import rme_pkg::*;

	// (x + y) mod n for x, y < n without growing past WIDTH bits
	function automatic logic [WIDTH-1:0] add_mod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
			logic [WIDTH-1:0] m);
		logic [WIDTH-1:0] room;
		room = m - y;
		if (x >= room) begin
			return x - room;
		end
		return x + y;
	endfunction

	logic [WIDTH-1:0] dbl;
	logic [WIDTH-1:0] nxt;

	always_comb begin
		dbl = add_mod(acc_i, acc_i, n);
		nxt = b_i[WIDTH-1] ? add_mod(dbl, a_i, n) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		acc_o <= nxt;
		a_o   <= a_i;
		b_o   <= {b_i[WIDTH-2:0], 1'b0};
	end

endmodule

[src/rme_chain.sv]
// Row of WIDTH multiplier cells, each registering one step; the product leaves the last cell.
// Depends on rme_pkg and rme_cell.
module rme_chain #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] n,
	output logic             done,
	output logic [WIDTH-1:0] product
);
	import rme_pkg::*;

	logic             v   [WIDTH+1];
	logic [WIDTH-1:0] acc [WIDTH+1];
	logic [WIDTH-1:0] av  [WIDTH+1];
	logic [WIDTH-1:0] bv  [WIDTH+1];

	assign v[0]   = start;
	assign acc[0] = '0;
	assign av[0]  = a;
	assign bv[0]  = b;

	for (genvar k = 0; k < WIDTH; k++) begin : g_cell
		rme_cell #(.WIDTH(WIDTH)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.n       (n),
			.valid_i (v[k]),
			.acc_i   (acc[k]),
			.a_i     (av[k]),
			.b_i     (bv[k]),
			.valid_o (v[k+1]),
			.acc_o   (acc[k+1]),
			.a_o     (av[k+1]),
			.b_o     (bv[k+1])
		);
	end

	assign done    = v[WIDTH];
	assign product = acc[WIDTH];

endmodule

[src/rsa_modular_exponentiation.sv]
// Top level: register port, sequencer for square-and-multiply, output register.
// Depends on rme_pkg and rme_chain.
//
//   channel  | valid         | stall         | payload
//   item     | item_valid    | item_stall    | mode, message
//   result   | result_valid  | result_stall  | result
//
// Each word first reduces the message in the WIDTH-cell multiplier row, then for each
// exponent bit (32 of them) squares the accumulator and, when the bit is set, multiplies
// it by the reduced message; last it loads the output register and raises result_valid.
// Exponent zero or modulus zero skip the multiplier row. Reset clears the registers to
// exponents 0, modulus 1. item_stall is high while a word is in work; a stalled result
// holds in the output register while the next word is taken.
module rsa_modular_exponentiation #(
	parameter int WIDTH = rme_pkg::RME_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rme_pkg::ADDR_W-1:0] paddr,
	input  logic [rme_pkg::DATA_W-1:0] pwdata,
	output logic [rme_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       mode,
	input  logic [31:0]                message,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [31:0]                result
);
	import rme_pkg::*;

	logic [31:0] pub_exp_q, priv_exp_q, modulus_q;
	reg_idx_t    widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_exp_q  <= '0;
			priv_exp_q <= '0;
			modulus_q  <= 32'd1;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_PUBLIC_EXP:  pub_exp_q  <= pwdata;
				REG_PRIVATE_EXP: priv_exp_q <= pwdata;
				REG_MODULUS:     modulus_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_PUBLIC_EXP:  prdata = pub_exp_q;
			REG_PRIVATE_EXP: prdata = priv_exp_q;
			REG_MODULUS:     prdata = modulus_q;
			default:         prdata = '0;
		endcase
	end

	// operand views at WIDTH bits
	logic [WIDTH-1:0] n_op, msg_op;
	if (WIDTH > 32) begin : g_wide
		assign n_op   = {{(WIDTH-32){1'b0}}, modulus_q};
		assign msg_op = {{(WIDTH-32){1'b0}}, message};
	end else begin : g_narrow
		assign n_op   = modulus_q[WIDTH-1:0];
		assign msg_op = message[WIDTH-1:0];
	end

	state_t           state_q, state_d;
	logic             start_q, start_d;
	logic [4:0]       bit_q;
	logic [31:0]      ex_q;
	logic [WIDTH-1:0] n_q, msg_q, base_q, acc_q;
	logic [WIDTH-1:0] mul_a, mul_b, product;
	logic             done;
	logic             accept, out_free;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !result_valid || !result_stall;

	always_comb begin
		state_d = state_q;
		start_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((mode ? priv_exp_q : pub_exp_q) == '0 || n_op == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_REDUCE;
						start_d = 1'b1;
					end
				end
			end
			ST_REDUCE: begin
				if (done) begin
					state_d = ST_SQR;
					start_d = 1'b1;
				end
			end
			ST_SQR: begin
				if (done) begin
					if (ex_q[bit_q]) begin
						state_d = ST_MUL;
						start_d = 1'b1;
					end else if (bit_q == '0) begin
						state_d = ST_DONE;
					end else begin
						start_d = 1'b1;
					end
				end
			end
			ST_MUL: begin
				if (done) begin
					if (bit_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SQR;
						start_d = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
		end
	end

	always_comb begin
		case (state_q)
			ST_REDUCE: begin
				mul_a = acc_q;
				mul_b = msg_q;
			end
			ST_MUL: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = acc_q;
				mul_b = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ex_q  <= mode ? priv_exp_q : pub_exp_q;
			n_q   <= n_op;
			msg_q <= msg_op;
			bit_q <= 5'd31;
			if ((mode ? priv_exp_q : pub_exp_q) == '0) begin
				acc_q <= WIDTH'(1);
			end else if (n_op == WIDTH'(1) || n_op == '0) begin
				acc_q <= '0;
			end else begin
				acc_q <= WIDTH'(1);
			end
		end else if (done) begin
			case (state_q)
				ST_REDUCE: base_q <= product;
				ST_SQR: begin
					acc_q <= product;
					if (!ex_q[bit_q] && bit_q != '0) begin
						bit_q <= bit_q - 5'd1;
					end
				end
				ST_MUL: begin
					acc_q <= product;
					if (bit_q != '0) begin
						bit_q <= bit_q - 5'd1;
					end
				end
				default: ;
			endcase
		end
	end

	rme_chain #(.WIDTH(WIDTH)) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.a       (mul_a),
		.b       (mul_b),
		.n       (n_q),
		.done    (done),
		.product (product)
	);

	logic [31:0] acc_out;
	if (WIDTH >= 32) begin : g_out_wide
		assign acc_out = acc_q[31:0];
	end else begin : g_out_narrow
		assign acc_out = {{(32-WIDTH){1'b0}}, acc_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result <= acc_out;
		end
	end

	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_REDUCE || state_q == ST_SQR || state_q == ST_MUL))
		else $error("multiplier product outside a multiply phase");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQR || state_q == ST_MUL) |-> acc_q < n_q)
		else $error("accumulator not reduced below modulus");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word did not start work");

endmodule
